[rtl/tsjf_pkg.sv]
// Shared types, constants and the adaptive coefficient table of the slider filter.
package tsjf_pkg;

  // Position and filter constants.
  localparam logic [6:0]  POS_MAX   = 7'd100;
  localparam int          Q14_SHIFT = 14;
  localparam logic [6:0]  SPEED_SLOW = 7'd2;
  localparam logic [6:0]  SPEED_FAST = 7'd10;

  // Coefficients at the ends of the adaptive range.
  localparam logic [14:0] KEEP_SLOW = 15'd15729;
  localparam logic [14:0] NEW_SLOW  = 15'd655;
  localparam logic [14:0] KEEP_FAST = 15'd14090;
  localparam logic [14:0] NEW_FAST  = 15'd2294;

  // Register reset values.
  localparam logic [7:0]  RST_RELEASE_FRAMES = 8'd3;
  localparam logic [14:0] RST_COEF_KEEP      = 15'd15401;
  localparam logic [14:0] RST_COEF_NEW       = 15'd983;
  localparam logic [3:0]  RST_RING_LENGTH    = 4'd8;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_RELEASE_FRAMES = 3'd0,
    CFG_COEF_KEEP      = 3'd1,
    CFG_COEF_NEW       = 3'd2,
    CFG_PREDICT_ON     = 3'd3,
    CFG_ADAPTIVE_ON    = 3'd4,
    CFG_RING_LENGTH    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  release_frames;
    logic [14:0] coef_keep;
    logic [14:0] coef_new;
    logic        predict_on;
    logic        adaptive_on;
    logic [3:0]  ring_length;
  } cfg_t;

  // A coefficient pair; we is set when the core overwrites the registers.
  typedef struct packed {
    logic        we;
    logic [14:0] keep;
    logic [14:0] fresh;
  } coef_upd_t;

  // History ring control from the core.
  typedef struct packed {
    logic       push;
    logic       clr_fill;
    logic [6:0] val;
  } ring_ctrl_t;

  // History ring status to the core.
  typedef struct packed {
    logic [6:0] last;
    logic [6:0] before_last;
    logic       two_ok;
  } ring_stat_t;

  typedef struct packed {
    logic       out_valid;
    logic [6:0] out_position;
  } result_t;

  // Coefficients as a function of speed: slow and fast ends, linear steps between.
  function automatic coef_upd_t adapt_coef(input logic [6:0] speed);
    coef_upd_t c;
    c.we = 1'b1;
    case (speed) inside
      [7'd0:SPEED_SLOW]: begin c.keep = KEEP_SLOW;  c.fresh = NEW_SLOW; end
      7'd3:              begin c.keep = 15'd15533; c.fresh = 15'd851;  end
      7'd4:              begin c.keep = 15'd15320; c.fresh = 15'd1064; end
      7'd5:              begin c.keep = 15'd15123; c.fresh = 15'd1261; end
      7'd6:              begin c.keep = 15'd14910; c.fresh = 15'd1474; end
      7'd7:              begin c.keep = 15'd14713; c.fresh = 15'd1671; end
      7'd8:              begin c.keep = 15'd14500; c.fresh = 15'd1884; end
      7'd9:              begin c.keep = 15'd14304; c.fresh = 15'd2080; end
      default:           begin c.keep = KEEP_FAST;  c.fresh = NEW_FAST; end
    endcase
    return c;
  endfunction

endpackage

[rtl/tsjf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsjf_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

[rtl/tsjf_cfg.sv]
// Configuration register file with the adaptive coefficient write-back.
module tsjf_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [2:0]            wr_index_i,
  input  logic [14:0]           wr_data_i,
  input  tsjf_pkg::coef_upd_t   coef_upd_i,
  output tsjf_pkg::cfg_t        cfg_o,
  output logic [3:0]            ring_length_next_o
);

  tsjf_pkg::cfg_t cfg_q, cfg_d;

  // Host writes take priority; the core rewrites the coefficients in adaptive mode.
  always_comb begin
    cfg_d = cfg_q;
    if (coef_upd_i.we) begin
      cfg_d.coef_keep = coef_upd_i.keep;
      cfg_d.coef_new  = coef_upd_i.fresh;
    end
    if (wr_en_i) begin
      case (tsjf_pkg::cfg_idx_e'(wr_index_i))
        tsjf_pkg::CFG_RELEASE_FRAMES: cfg_d.release_frames = wr_data_i[7:0];
        tsjf_pkg::CFG_COEF_KEEP:      cfg_d.coef_keep      = wr_data_i;
        tsjf_pkg::CFG_COEF_NEW:       cfg_d.coef_new       = wr_data_i;
        tsjf_pkg::CFG_PREDICT_ON:     cfg_d.predict_on     = wr_data_i[0];
        tsjf_pkg::CFG_ADAPTIVE_ON:    cfg_d.adaptive_on    = wr_data_i[0];
        tsjf_pkg::CFG_RING_LENGTH:    cfg_d.ring_length    = wr_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.release_frames <= tsjf_pkg::RST_RELEASE_FRAMES;
      cfg_q.coef_keep      <= tsjf_pkg::RST_COEF_KEEP;
      cfg_q.coef_new       <= tsjf_pkg::RST_COEF_NEW;
      cfg_q.predict_on     <= 1'b0;
      cfg_q.adaptive_on    <= 1'b0;
      cfg_q.ring_length    <= tsjf_pkg::RST_RING_LENGTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o              = cfg_q;
  assign ring_length_next_o = cfg_d.ring_length;

endmodule

[rtl/tsjf_ring.sv]
// History ring: pointer, fill count, entry valid bits and two RAM read ports.
module tsjf_ring #(
  parameter int RING_DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           ring_length_i,
  input  logic [3:0]           ring_length_next_i,
  input  tsjf_pkg::ring_ctrl_t ctrl_i,
  output tsjf_pkg::ring_stat_t stat_o
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  // Entries in use: the programmed length clamped to 1..RING_DEPTH.
  function automatic logic [CNT_W-1:0] len_used(input logic [3:0] len);
    logic [CNT_W-1:0] n;
    if (len == 4'd0) begin
      n = CNT_W'(1);
    end else if (32'(len) > RING_DEPTH) begin
      n = CNT_W'(RING_DEPTH);
    end else begin
      n = CNT_W'(len);
    end
    return n;
  endfunction

  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [RING_DEPTH-1:0] ent_vld_q;
  logic [CNT_W-1:0]      n_cur, n_nxt, p_cur, p_nxt, fill_cap;
  logic [CNT_W-1:0]      last_a, prev_a;
  logic [PTR_W-1:0]      waddr, last_addr, prev_addr;
  logic [6:0]            wdat_q, last_rd, prev_rd;
  logic                  last_byp_q, prev_byp_q, last_vld_q, prev_vld_q;

  // Pointer and fill update on a push or a release.
  always_comb begin
    n_cur    = len_used(ring_length_i);
    p_cur    = (CNT_W'(ptr_q) >= n_cur) ? '0 : CNT_W'(ptr_q);
    waddr    = PTR_W'(p_cur);
    fill_cap = (fill_q > n_cur) ? n_cur : fill_q;
    ptr_d    = ptr_q;
    fill_d   = fill_q;
    if (ctrl_i.push) begin
      ptr_d  = (p_cur + CNT_W'(1) == n_cur) ? '0 : PTR_W'(p_cur + CNT_W'(1));
      fill_d = (fill_cap < n_cur) ? fill_cap + CNT_W'(1) : fill_cap;
    end else if (ctrl_i.clr_fill) begin
      fill_d = '0;
    end
  end

  // Read addresses of the two newest entries as seen after this cycle's update.
  always_comb begin
    n_nxt = len_used(ring_length_next_i);
    p_nxt = (CNT_W'(ptr_d) >= n_nxt) ? '0 : CNT_W'(ptr_d);
    last_a = (p_nxt == '0) ? n_nxt - CNT_W'(1) : p_nxt - CNT_W'(1);
    if (p_nxt >= CNT_W'(2)) begin
      prev_a = p_nxt - CNT_W'(2);
    end else if (p_nxt == CNT_W'(1)) begin
      prev_a = n_nxt - CNT_W'(1);
    end else if (n_nxt >= CNT_W'(2)) begin
      prev_a = n_nxt - CNT_W'(2);
    end else begin
      prev_a = '0;
    end
    last_addr = PTR_W'(last_a);
    prev_addr = PTR_W'(prev_a);
  end

  // Control state, valid bits and write bypass flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      fill_q     <= '0;
      ent_vld_q  <= '0;
      last_byp_q <= 1'b0;
      prev_byp_q <= 1'b0;
      last_vld_q <= 1'b0;
      prev_vld_q <= 1'b0;
    end else begin
      ptr_q      <= ptr_d;
      fill_q     <= fill_d;
      if (ctrl_i.push) begin
        ent_vld_q[waddr] <= 1'b1;
      end
      last_byp_q <= ctrl_i.push && (last_addr == waddr);
      prev_byp_q <= ctrl_i.push && (prev_addr == waddr);
      last_vld_q <= ent_vld_q[last_addr];
      prev_vld_q <= ent_vld_q[prev_addr];
    end
  end

  // Written value kept for the bypass.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      wdat_q <= ctrl_i.val;
    end
  end

  tsjf_ram #(.WIDTH(7), .DEPTH(RING_DEPTH)) u_ram_last (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (waddr),
    .wdata_i (ctrl_i.val),
    .raddr_i (last_addr),
    .rdata_o (last_rd)
  );

  tsjf_ram #(.WIDTH(7), .DEPTH(RING_DEPTH)) u_ram_prev (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (waddr),
    .wdata_i (ctrl_i.val),
    .raddr_i (prev_addr),
    .rdata_o (prev_rd)
  );

  // Entries never written read as zero.
  always_comb begin
    stat_o.last        = last_byp_q ? wdat_q : (last_vld_q ? last_rd : 7'd0);
    stat_o.before_last = prev_byp_q ? wdat_q : (prev_vld_q ? prev_rd : 7'd0);
    stat_o.two_ok      = (fill_q >= CNT_W'(2));
  end

endmodule

[rtl/tsjf_core.sv]
// Filter state and the single-pass step: speed, coefficients, prediction, IIR, release.
module tsjf_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  touched_i,
  input  logic [6:0]            position_i,
  input  logic [31:0]           time_ms_i,
  input  tsjf_pkg::cfg_t        cfg_i,
  input  tsjf_pkg::ring_stat_t  ring_i,
  output tsjf_pkg::ring_ctrl_t  ring_o,
  output tsjf_pkg::coef_upd_t   coef_o,
  output tsjf_pkg::result_t     res_o
);

  logic [6:0]  filt_q, filt_d;
  logic        track_q, track_d;
  logic [7:0]  miss_q, miss_d, miss_inc;
  logic        praw_vld_q, praw_vld_d;
  logic [6:0]  praw_q, praw_d;
  logic [6:0]  speed_q, speed_d, speed_new, diff;
  logic [31:0] ptime_q, ptime_d;

  logic [6:0]  pos_sat, guess, gap, x_sel, iir_y, iir_out;
  logic [7:0]  guess_sum;
  logic        do_pred;
  logic [14:0] ck, cn;
  logic [21:0] prod_keep, prod_new;
  logic [22:0] acc;
  logic [8:0]  scaled;
  tsjf_pkg::coef_upd_t tab;

  // Speed, coefficient choice and the linear guess.
  always_comb begin
    pos_sat   = (position_i > tsjf_pkg::POS_MAX) ? tsjf_pkg::POS_MAX : position_i;
    diff      = (pos_sat >= praw_q) ? pos_sat - praw_q : praw_q - pos_sat;
    speed_new = (praw_vld_q && (ptime_q != 32'd0) && (time_ms_i != ptime_q)) ? diff : speed_q;
    tab       = tsjf_pkg::adapt_coef(speed_new);

    guess_sum = '0;
    gap       = '0;
    if (ring_i.last > ring_i.before_last) begin
      guess_sum = {1'b0, ring_i.last} + {1'b0, ring_i.last - ring_i.before_last};
      guess = (guess_sum > {1'b0, tsjf_pkg::POS_MAX}) ? tsjf_pkg::POS_MAX : guess_sum[6:0];
    end else if (ring_i.last < ring_i.before_last) begin
      gap   = ring_i.before_last - ring_i.last;
      guess = (ring_i.last >= gap) ? ring_i.last - gap : 7'd0;
    end else begin
      guess = ring_i.last;
    end

    miss_inc = miss_q + 8'd1;
    do_pred  = cfg_i.predict_on && (miss_inc == 8'd1) && ring_i.two_ok;
  end

  // Q14 first-order filter on the selected sample.
  always_comb begin
    x_sel     = touched_i ? pos_sat : guess;
    ck        = (touched_i && cfg_i.adaptive_on) ? tab.keep  : cfg_i.coef_keep;
    cn        = (touched_i && cfg_i.adaptive_on) ? tab.fresh : cfg_i.coef_new;
    prod_keep = filt_q * ck;
    prod_new  = x_sel * cn;
    acc       = {1'b0, prod_keep} + {1'b0, prod_new};
    scaled    = acc[22:tsjf_pkg::Q14_SHIFT];
    iir_y     = (scaled > {2'b00, tsjf_pkg::POS_MAX}) ? tsjf_pkg::POS_MAX : scaled[6:0];
    iir_out   = track_q ? iir_y : x_sel;
  end

  // Next state, ring and coefficient requests, and the result.
  always_comb begin
    filt_d     = filt_q;
    track_d    = track_q;
    miss_d     = miss_q;
    praw_vld_d = praw_vld_q;
    praw_d     = praw_q;
    speed_d    = speed_q;
    ptime_d    = ptime_q;
    ring_o     = '0;
    coef_o     = '0;
    res_o      = '0;
    if (touched_i) begin
      miss_d       = '0;
      speed_d      = speed_new;
      praw_d       = pos_sat;
      praw_vld_d   = 1'b1;
      ptime_d      = time_ms_i;
      coef_o       = cfg_i.adaptive_on ? tab : '0;
      ring_o.push  = 1'b1;
      ring_o.val   = pos_sat;
      filt_d       = iir_out;
      track_d      = 1'b1;
      res_o.out_valid    = 1'b1;
      res_o.out_position = iir_out;
    end else if (track_q) begin
      miss_d = miss_inc;
      if (do_pred) begin
        ring_o.push        = 1'b1;
        ring_o.val         = guess;
        filt_d             = iir_out;
        res_o.out_valid    = 1'b1;
        res_o.out_position = iir_out;
      end else if (miss_inc < cfg_i.release_frames) begin
        res_o.out_valid    = 1'b1;
        res_o.out_position = filt_q;
      end else begin
        // Release: forget tracking, fill and speed; keep the last output value.
        track_d         = 1'b0;
        miss_d          = '0;
        praw_vld_d      = 1'b0;
        speed_d         = '0;
        ring_o.clr_fill = 1'b1;
      end
    end
    if (!step_i) begin
      ring_o = '0;
      coef_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q     <= '0;
      track_q    <= 1'b0;
      miss_q     <= '0;
      praw_vld_q <= 1'b0;
      praw_q     <= '0;
      speed_q    <= '0;
      ptime_q    <= '0;
    end else if (step_i) begin
      filt_q     <= filt_d;
      track_q    <= track_d;
      miss_q     <= miss_d;
      praw_vld_q <= praw_vld_d;
      praw_q     <= praw_d;
      speed_q    <= speed_d;
      ptime_q    <= ptime_d;
    end
  end

endmodule

[rtl/touch_slider_jump_filter_top.sv]
// Top level of the touch slider jump filter: handshakes, input and result registers.
//
// Input channel: in_valid_i / in_stall_o carry one frame request (touched_i,
// position_i, time_ms_i); a request is taken at a clock edge with in_valid_i
// high and in_stall_o low. Result channel: res_valid_o / res_stall_i carry one
// result (out_valid_o, out_position_o) for every accepted frame, in order.
// Configuration: cfg_valid_i / cfg_ready_o with a register index and data;
// cfg_ready_o is always high and indexes beyond the register list are ignored.
// Order: a taken frame is processed from the input register, and its result is loaded
// into the result register when the frame advances; the result is taken from there.
// Throughput: one frame per cycle unless res_stall_i holds a result back; the filter
// state loop and the history RAM read ports do not limit it.
// Reset clears the filter state, the history ring and the registers to their
// defaults; no clearing pass is needed, and frames are accepted right away.
// When res_stall_i holds a finished result, the frame in the input register
// waits behind it and in_stall_o rises only once both stages are occupied.
module touch_slider_jump_filter_top #(
  parameter int RING_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        touched_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] time_ms_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        out_valid_o,
  output logic [6:0]  out_position_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);

  logic        s1_vld_q, s1_vld_d;
  logic        s1_touched_q;
  logic [6:0]  s1_pos_q;
  logic [31:0] s1_time_q;
  logic        res_vld_q, res_vld_d;
  tsjf_pkg::result_t    res_q, res_d;
  logic        advance, accept, take;
  logic [3:0]  ring_length_next;
  tsjf_pkg::cfg_t       cfg;
  tsjf_pkg::coef_upd_t  coef_upd;
  tsjf_pkg::ring_ctrl_t ring_ctrl;
  tsjf_pkg::ring_stat_t ring_stat;

  // Pipeline handshake: the frame advances when the result register is free.
  assign advance     = s1_vld_q && (!res_vld_q || !res_stall_i);
  assign in_stall_o  = s1_vld_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign take        = res_vld_q && !res_stall_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_vld_d  = accept ? 1'b1 : (advance ? 1'b0 : s1_vld_q);
    res_vld_d = advance ? 1'b1 : (take ? 1'b0 : res_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_touched_q <= touched_i;
      s1_pos_q     <= position_i;
      s1_time_q    <= time_ms_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  tsjf_cfg u_cfg (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .wr_en_i            (cfg_valid_i && cfg_ready_o),
    .wr_index_i         (cfg_index_i),
    .wr_data_i          (cfg_data_i),
    .coef_upd_i         (coef_upd),
    .cfg_o              (cfg),
    .ring_length_next_o (ring_length_next)
  );

  tsjf_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ring_length_i      (cfg.ring_length),
    .ring_length_next_i (ring_length_next),
    .ctrl_i             (ring_ctrl),
    .stat_o             (ring_stat)
  );

  tsjf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .touched_i  (s1_touched_q),
    .position_i (s1_pos_q),
    .time_ms_i  (s1_time_q),
    .cfg_i      (cfg),
    .ring_i     (ring_stat),
    .ring_o     (ring_ctrl),
    .coef_o     (coef_upd),
    .res_o      (res_d)
  );

  assign res_valid_o    = res_vld_q;
  assign out_valid_o    = res_q.out_valid;
  assign out_position_o = res_q.out_position;

endmodule

[verif/tb_touch_slider_jump_filter_top.sv]
// Self-checking testbench for the touch slider jump filter top level.
module tb_touch_slider_jump_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 8;
  // Register index past the end of the list; the block must ignore it.
  localparam logic [2:0] CFG_SPARE = 3'd6;

  typedef enum logic {ROW_FRAME, ROW_REG} row_kind_e;

  // One row of the directed plan: either a frame request or a register write.
  typedef struct {
    row_kind_e         kind;
    logic [2:0]        idx;
    logic [14:0]       data;
    bit                touch;
    logic [6:0]        pos;
    logic [31:0]       stamp;
    bit                known;
    tsjf_pkg::result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        touched = 1'b0;
  logic [6:0]  position = '0;
  logic [31:0] time_ms = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        out_valid;
  logic [6:0]  out_position;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  // Idle rates in percent of cycles for the frame sender and the result receiver.
  int unsigned send_idle_pct = 20;
  int unsigned recv_stall_pct = 78;

  // Results still owed by the block, oldest first.
  tsjf_pkg::result_t expected_q[$];
  plan_row_t plan[$];

  int unsigned fail_count = 0;
  int unsigned frames_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned guesses_made = 0;
  int unsigned releases_seen = 0;

  // Filter model state and its copy of the registers.
  tsjf_pkg::cfg_t regs;
  logic [6:0]  held_pos;
  bit          tracking_now;
  logic [7:0]  misses;
  logic [6:0]  trail [HIST_DEPTH];
  logic [2:0]  trail_ptr;
  logic [3:0]  trail_fill;
  bit          raw_seen;
  logic [6:0]  raw_prev;
  logic [6:0]  speed;
  logic [31:0] stamp_prev;

  touch_slider_jump_filter_top #(
    .RING_DEPTH(HIST_DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .touched_i     (touched),
    .position_i    (position),
    .time_ms_i     (time_ms),
    .res_valid_o   (res_valid),
    .res_stall_i   (res_stall),
    .out_valid_o   (out_valid),
    .out_position_o(out_position),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // History entries in use, with the out-of-range lengths folded in.
  function automatic int ring_span();
    int n;
    n = int'(regs.ring_length);
    if (n < 1) n = 1;
    if (n > HIST_DEPTH) n = HIST_DEPTH;
    return n;
  endfunction

  function automatic void push_trail(int v);
    int n, p;
    n = ring_span();
    p = int'(trail_ptr);
    if (p >= n) p = 0;
    trail[p] = 7'(v);
    trail_ptr = 3'((p + 1) % n);
    if (int'(trail_fill) > n) trail_fill = 4'(n);
    if (int'(trail_fill) < n) trail_fill = trail_fill + 4'd1;
  endfunction

  // Linear extrapolation from the two newest history entries, clamped to 0..100.
  function automatic int guess_next();
    int n, p, last, prior, d;
    n = ring_span();
    p = int'(trail_ptr);
    if (p >= n) p = 0;
    last = int'(trail[(p + n - 1) % n]);
    prior = int'(trail[(p + 2 * n - 2) % n]);
    if (last > prior) begin
      d = 2 * last - prior;
      return (d > int'(tsjf_pkg::POS_MAX)) ? int'(tsjf_pkg::POS_MAX) : d;
    end
    if (last < prior) begin
      d = prior - last;
      return (last >= d) ? last - d : 0;
    end
    return last;
  endfunction

  // Coefficients from the measured speed; the step is spread over the slow-to-fast span.
  function automatic void adapt_coefs();
    int s, r, step;
    s = int'(speed);
    step = int'(tsjf_pkg::KEEP_SLOW) - int'(tsjf_pkg::KEEP_FAST);
    if (s <= int'(tsjf_pkg::SPEED_SLOW)) begin
      regs.coef_keep = tsjf_pkg::KEEP_SLOW;
      regs.coef_new = tsjf_pkg::NEW_SLOW;
    end else if (s >= int'(tsjf_pkg::SPEED_FAST)) begin
      regs.coef_keep = tsjf_pkg::KEEP_FAST;
      regs.coef_new = tsjf_pkg::NEW_FAST;
    end else begin
      r = ((s - int'(tsjf_pkg::SPEED_SLOW)) * 100) /
          (int'(tsjf_pkg::SPEED_FAST) - int'(tsjf_pkg::SPEED_SLOW));
      regs.coef_keep = 15'(int'(tsjf_pkg::KEEP_SLOW) - (step * r) / 100);
      regs.coef_new = 15'(int'(tsjf_pkg::NEW_SLOW) + (step * r) / 100);
    end
  endfunction

  // Q14 first-order smoothing; the first sample after release loads directly.
  function automatic int smooth(int x);
    int s;
    if (!tracking_now) begin
      held_pos = 7'(x);
      tracking_now = 1'b1;
      return x;
    end
    s = (int'(held_pos) * int'(regs.coef_keep) + x * int'(regs.coef_new))
        >> tsjf_pkg::Q14_SHIFT;
    if (s > int'(tsjf_pkg::POS_MAX)) s = int'(tsjf_pkg::POS_MAX);
    held_pos = 7'(s);
    return s;
  endfunction

  // Expected result of one frame request; updates the model state.
  function automatic tsjf_pkg::result_t filter_frame(bit tch, logic [6:0] p, logic [31:0] s);
    tsjf_pkg::result_t r;
    int x, y;
    r = '0;
    if (!tch) begin
      if (!tracking_now) return r;
      misses = misses + 8'd1;
      if (regs.predict_on && misses == 8'd1 && trail_fill >= 4'd2) begin
        x = guess_next();
        push_trail(x);
        y = smooth(x);
        guesses_made++;
        r.out_valid = 1'b1;
        r.out_position = 7'(y);
        return r;
      end
      if (misses < regs.release_frames) begin
        r.out_valid = 1'b1;
        r.out_position = held_pos;
        return r;
      end
      // Too many missed frames: let go of the slider.
      tracking_now = 1'b0;
      misses = '0;
      trail_fill = '0;
      raw_seen = 1'b0;
      speed = '0;
      releases_seen++;
      return r;
    end
    x = (p > tsjf_pkg::POS_MAX) ? int'(tsjf_pkg::POS_MAX) : int'(p);
    misses = '0;
    if (raw_seen && stamp_prev != 32'd0 && s != stamp_prev) begin
      speed = 7'((x >= int'(raw_prev)) ? x - int'(raw_prev) : int'(raw_prev) - x);
    end
    raw_prev = 7'(x);
    raw_seen = 1'b1;
    stamp_prev = s;
    if (regs.adaptive_on) adapt_coefs();
    push_trail(x);
    y = smooth(x);
    r.out_valid = 1'b1;
    r.out_position = 7'(y);
    return r;
  endfunction

  function automatic plan_row_t frame_row(bit tch, int p, logic [31:0] s);
    plan_row_t row;
    row = '{kind: ROW_FRAME, idx: tsjf_pkg::CFG_RELEASE_FRAMES, data: '0, touch: tch,
            pos: 7'(p), stamp: s, known: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t known_row(bit tch, int p, logic [31:0] s, bit v, int y);
    plan_row_t row;
    row = frame_row(tch, p, s);
    row.known = 1'b1;
    row.want.out_valid = v;
    row.want.out_position = 7'(y);
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [2:0] idx, int data);
    plan_row_t row;
    row = frame_row(1'b0, 0, '0);
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = 15'(data);
    return row;
  endfunction

  // Offer one frame request, with a random gap first, and wait until it is taken.
  task automatic send_frame(bit tch, logic [6:0] p, logic [31:0] s, bit known,
                            tsjf_pkg::result_t want);
    int gap;
    tsjf_pkg::result_t got;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    touched <= tch;
    position <= p;
    time_ms <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = filter_frame(tch, p, s);
    expected_q.push_back(known ? want : got);
    frames_sent++;
  endtask

  // Hold off new requests until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [14:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tsjf_pkg::CFG_RELEASE_FRAMES: regs.release_frames = data[7:0];
      tsjf_pkg::CFG_COEF_KEEP:      regs.coef_keep = data;
      tsjf_pkg::CFG_COEF_NEW:       regs.coef_new = data;
      tsjf_pkg::CFG_PREDICT_ON:     regs.predict_on = data[0];
      tsjf_pkg::CFG_ADAPTIVE_ON:    regs.adaptive_on = data[0];
      tsjf_pkg::CFG_RING_LENGTH:    regs.ring_length = data[3:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // New random settings for a phase, now and then at or past the ends of the ranges.
  task automatic shuffle_regs();
    int keep;
    case ($urandom_range(0, 9))
      0: write_reg(tsjf_pkg::CFG_RELEASE_FRAMES, 15'd0);
      1: write_reg(tsjf_pkg::CFG_RELEASE_FRAMES, 15'd255);
      default: write_reg(tsjf_pkg::CFG_RELEASE_FRAMES, 15'($urandom_range(1, 6)));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      write_reg(tsjf_pkg::CFG_COEF_KEEP, 15'($urandom_range(0, 32767)));
      write_reg(tsjf_pkg::CFG_COEF_NEW, 15'($urandom_range(0, 32767)));
    end else begin
      keep = int'($urandom_range(12000, 16384));
      write_reg(tsjf_pkg::CFG_COEF_KEEP, 15'(keep));
      write_reg(tsjf_pkg::CFG_COEF_NEW, 15'(16384 - keep));
    end
    write_reg(tsjf_pkg::CFG_PREDICT_ON, 15'($urandom_range(0, 1)));
    write_reg(tsjf_pkg::CFG_ADAPTIVE_ON, 15'($urandom_range(0, 1)));
    if ($urandom_range(0, 5) == 0) begin
      write_reg(tsjf_pkg::CFG_RING_LENGTH, 15'($urandom_range(0, 15)));
    end else begin
      write_reg(tsjf_pkg::CFG_RING_LENGTH, 15'($urandom_range(2, HIST_DEPTH)));
    end
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Compare every accepted result with the oldest owed one.
  always @(posedge clk) begin : result_check
    tsjf_pkg::result_t want;
    if (rst_n && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no request waiting: out_valid %0d, out_position %0d",
               out_valid, out_position);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (out_valid !== want.out_valid) begin
          $error("out_valid: expected %0d, got %0d", want.out_valid, out_valid);
          fail_count++;
        end
        if (out_position !== want.out_position) begin
          $error("out_position: expected %0d, got %0d", want.out_position, out_position);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int finger, run, lift, mark;
    logic [31:0] ms_now;

    // Model state after reset.
    regs.release_frames = tsjf_pkg::RST_RELEASE_FRAMES;
    regs.coef_keep = tsjf_pkg::RST_COEF_KEEP;
    regs.coef_new = tsjf_pkg::RST_COEF_NEW;
    regs.predict_on = 1'b0;
    regs.adaptive_on = 1'b0;
    regs.ring_length = tsjf_pkg::RST_RING_LENGTH;
    held_pos = '0;
    tracking_now = 1'b0;
    misses = '0;
    for (int i = 0; i < HIST_DEPTH; i++) trail[i] = '0;
    trail_ptr = '0;
    trail_fill = '0;
    raw_seen = 1'b0;
    raw_prev = '0;
    speed = '0;
    stamp_prev = '0;

    // Directed plan. Default settings: idle before any touch, saturation,
    // extreme timestamps, hold and release after three missed frames.
    plan.push_back(known_row(1'b0, 127, 32'd0, 1'b0, 0));
    plan.push_back(known_row(1'b1, 127, 32'd0, 1'b1, 100));
    plan.push_back(frame_row(1'b1, 0, 32'd1));
    plan.push_back(frame_row(1'b1, 101, 32'hFFFF_FFFF));
    plan.push_back(frame_row(1'b0, 55, 32'd7));
    plan.push_back(frame_row(1'b0, 0, 32'd8));
    plan.push_back(known_row(1'b0, 127, 32'd9, 1'b0, 0));
    plan.push_back(known_row(1'b0, 3, 32'd10, 1'b0, 0));
    // Prediction and adaptive coefficients, a zero release count and a short ring.
    plan.push_back(reg_row(tsjf_pkg::CFG_PREDICT_ON, 1));
    plan.push_back(reg_row(tsjf_pkg::CFG_ADAPTIVE_ON, 1));
    plan.push_back(reg_row(tsjf_pkg::CFG_RELEASE_FRAMES, 0));
    plan.push_back(reg_row(tsjf_pkg::CFG_RING_LENGTH, 2));
    plan.push_back(known_row(1'b1, 10, 32'd100, 1'b1, 10));
    plan.push_back(frame_row(1'b1, 30, 32'd110));
    plan.push_back(frame_row(1'b1, 35, 32'd110));
    plan.push_back(frame_row(1'b1, 41, 32'd120));
    plan.push_back(frame_row(1'b0, 0, 32'd130));
    plan.push_back(known_row(1'b0, 0, 32'd140, 1'b0, 0));
    // Oversized ring length and coefficients that push the sum past full scale.
    plan.push_back(reg_row(tsjf_pkg::CFG_RING_LENGTH, 15));
    plan.push_back(reg_row(tsjf_pkg::CFG_ADAPTIVE_ON, 0));
    plan.push_back(reg_row(tsjf_pkg::CFG_COEF_KEEP, 32767));
    plan.push_back(reg_row(tsjf_pkg::CFG_COEF_NEW, 32767));
    plan.push_back(reg_row(tsjf_pkg::CFG_RELEASE_FRAMES, 255));
    plan.push_back(known_row(1'b1, 50, 32'd0, 1'b1, 50));
    plan.push_back(known_row(1'b1, 60, 32'd0, 1'b1, 100));
    plan.push_back(frame_row(1'b1, 0, 32'd0));
    plan.push_back(reg_row(tsjf_pkg::CFG_COEF_KEEP, 0));
    plan.push_back(reg_row(tsjf_pkg::CFG_COEF_NEW, 16384));
    plan.push_back(known_row(1'b1, 77, 32'd3, 1'b1, 77));
    plan.push_back(frame_row(1'b0, 127, 32'd4));
    plan.push_back(frame_row(1'b0, 1, 32'd5));
    // Pure hold filter with a zero ring length, then an ignored index and defaults.
    plan.push_back(reg_row(tsjf_pkg::CFG_COEF_KEEP, 16384));
    plan.push_back(reg_row(tsjf_pkg::CFG_COEF_NEW, 0));
    plan.push_back(reg_row(tsjf_pkg::CFG_RING_LENGTH, 0));
    plan.push_back(frame_row(1'b1, 20, 32'd9));
    plan.push_back(frame_row(1'b0, 64, 32'd11));
    plan.push_back(reg_row(CFG_SPARE, 32767));
    plan.push_back(reg_row(tsjf_pkg::CFG_RELEASE_FRAMES, 3));
    plan.push_back(reg_row(tsjf_pkg::CFG_COEF_KEEP, 15401));
    plan.push_back(reg_row(tsjf_pkg::CFG_COEF_NEW, 983));
    plan.push_back(reg_row(tsjf_pkg::CFG_PREDICT_ON, 0));
    plan.push_back(reg_row(tsjf_pkg::CFG_ADAPTIVE_ON, 0));
    plan.push_back(reg_row(tsjf_pkg::CFG_RING_LENGTH, 8));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_frame(plan[i].touch, plan[i].pos, plan[i].stamp, plan[i].known, plan[i].want);
      end
    end

    // Random phases: mostly touch strokes followed by lift-offs, some noise.
    finger = 50;
    ms_now = $urandom();
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph / 2)
        0: begin
          send_idle_pct = 20;
          recv_stall_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_stall_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      shuffle_regs();
      mark = frames_sent;
      while (frames_sent - mark < 85) begin
        if ($urandom_range(0, 9) < 7) begin
          run = int'($urandom_range(1, 12));
          for (int k = 0; k < run; k++) begin
            if ($urandom_range(0, 9) == 0) finger = int'($urandom_range(0, 127));
            else finger = finger + int'($urandom_range(0, 20)) - 10;
            if (finger < 0) finger = 0;
            if (finger > 127) finger = 127;
            ms_now = ms_now + $urandom_range(0, 30);
            send_frame(1'b1, 7'(finger), ($urandom_range(0, 19) == 0) ? 32'd0 : ms_now,
                       1'b0, '0);
          end
          lift = int'(regs.release_frames) + 2;
          if (lift > 10) lift = 10;
          run = int'($urandom_range(0, lift));
          for (int k = 0; k < run; k++) begin
            ms_now = ms_now + $urandom_range(1, 30);
            send_frame(1'b0, 7'($urandom_range(0, 127)), ms_now, 1'b0, '0);
          end
        end else begin
          run = int'($urandom_range(1, 6));
          for (int k = 0; k < run; k++) begin
            send_frame(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), $urandom(),
                       1'b0, '0);
          end
        end
        // Now and then let the pipeline run dry before going on.
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    $display("Sent %0d frame requests and %0d register writes; checked %0d results.",
             frames_sent, reg_writes, results_checked);
    $display("Model saw %0d trend guesses and %0d releases.", guesses_made, releases_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
